/* rtl/btpm_pkg.sv */
// shared types and constants of the binary trie prefix match engine
`default_nettype none

package btpm_pkg;

  localparam int DEF_NODE_COUNT   = 4096;
  localparam int DEF_ADDRESS_BITS = 32;

  localparam int ADDR_W  = 32;
  localparam int LEVEL_W = 6;
  localparam int PORT_W  = 16;

  localparam logic [LEVEL_W-1:0] DEPTH_RESET = 6'd32;

  localparam logic CMD_LOOKUP  = 1'b0;
  localparam logic CMD_INSERT  = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic               command;
    logic [ADDR_W-1:0]  ip_address;
    logic [LEVEL_W-1:0] prefix_length;
    logic [PORT_W-1:0]  route_port;
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] match_port;
    logic              found;
    logic              status;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/btpm_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module btpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/btpm_ctrl.sv */
// trie walk and route insert sequencer around the node store
`default_nettype none

module btpm_ctrl
  import btpm_pkg::*;
#(
  parameter int NODE_COUNT   = DEF_NODE_COUNT,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  localparam int IW     = $clog2(NODE_COUNT),
  localparam int NW     = $clog2(NODE_COUNT + 1),
  localparam int NODE_W = 2 * IW + 1 + PORT_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire req_t               request,
  input  wire logic [LEVEL_W-1:0] lookup_depth,
  output logic                    done,
  output rsp_t                    result,
  output logic                    ram_we,
  output logic [IW-1:0]           ram_waddr,
  output logic [NODE_W-1:0]       ram_wdata,
  output logic                    ram_re,
  output logic [IW-1:0]           ram_raddr,
  input  wire logic [NODE_W-1:0]  ram_rdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WCUR = 3'd3;
  localparam logic [2:0] ST_WNEW = 3'd4;

  localparam logic [LEVEL_W-1:0] AB_V = LEVEL_W'(ADDRESS_BITS);
  localparam logic [NW-1:0]      NC_V = NW'(NODE_COUNT);

  // node layout: left, right, mark, port
  localparam int L_LO = IW + 1 + PORT_W;
  localparam int R_LO = 1 + PORT_W;
  localparam int M_B  = PORT_W;

  logic [2:0]              state;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic                    cmd_q;
  logic [PORT_W-1:0]       port_q;
  logic [LEVEL_W-1:0]      limit;
  logic [LEVEL_W-1:0]      lvl;
  logic [LEVEL_W-1:0]      rem;
  logic [IW-1:0]           cur;
  logic [NODE_W-1:0]       node_q;
  logic                    root_valid;
  logic [NW-1:0]           next_free_node;
  logic                    hit;
  logic [PORT_W-1:0]       best;

  logic [NODE_W-1:0]  node_rd;
  logic [IW-1:0]      child;
  logic               bit_now;
  logic               go_on;
  logic [LEVEL_W-1:0] plen_sat;
  logic [LEVEL_W-1:0] depth_sat;
  logic [NW-1:0]      space;
  logic [IW-1:0]      fresh;
  logic [IW-1:0]      fresh_next;
  logic               hit_next;
  logic [PORT_W-1:0]  best_next;

  assign busy     = (state != ST_IDLE);
  assign bit_now  = addr_q[ADDRESS_BITS-1];
  assign node_rd  = (cur == '0 && !root_valid) ? '0 : ram_rdata;
  assign child    = bit_now ? node_rd[R_LO +: IW] : node_rd[L_LO +: IW];
  assign go_on    = (lvl < limit) && (child != '0);
  assign plen_sat = (request.prefix_length > AB_V) ? AB_V : request.prefix_length;
  assign depth_sat = (lookup_depth > AB_V) ? AB_V : lookup_depth;
  assign space    = NC_V - next_free_node;
  assign fresh    = next_free_node[IW-1:0];
  assign fresh_next = fresh + IW'(1);
  assign hit_next  = hit || node_rd[M_B];
  assign best_next = node_rd[M_B] ? node_rd[PORT_W-1:0] : best;

  // ram read side
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state == ST_IDLE) begin
      ram_re = start;
    end else if (state == ST_WALK) begin
      ram_re    = go_on;
      ram_raddr = child;
    end
  end

  // ram write side
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = node_q;
    if (state == ST_WCUR) begin
      ram_we = 1'b1;
      if (rem == '0) begin
        ram_wdata[M_B]          = 1'b1;
        ram_wdata[PORT_W-1:0]   = port_q;
      end else if (bit_now) begin
        ram_wdata[R_LO +: IW]   = fresh;
      end else begin
        ram_wdata[L_LO +: IW]   = fresh;
      end
    end else if (state == ST_WNEW) begin
      ram_we    = 1'b1;
      ram_waddr = fresh;
      ram_wdata = '0;
      if (rem == LEVEL_W'(1)) begin
        ram_wdata[M_B]        = 1'b1;
        ram_wdata[PORT_W-1:0] = port_q;
      end else if (bit_now) begin
        ram_wdata[R_LO +: IW] = fresh_next;
      end else begin
        ram_wdata[L_LO +: IW] = fresh_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      root_valid     <= 1'b0;
      next_free_node <= NW'(1);
    end else begin
      done <= 1'b0;
      if (ram_we && ram_waddr == '0) begin
        root_valid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!go_on) begin
            if (cmd_q == CMD_INSERT) begin
              state <= ST_CHECK;
            end else begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          if (next_free_node > NC_V || NW'(rem) > space) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_WCUR;
          end
        end
        ST_WCUR: begin
          if (rem == '0) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_WNEW;
          end
        end
        ST_WNEW: begin
          next_free_node <= next_free_node + NW'(1);
          if (rem == LEVEL_W'(1)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          addr_q <= request.ip_address[ADDRESS_BITS-1:0];
          cmd_q  <= request.command;
          port_q <= request.route_port;
          limit  <= (request.command == CMD_INSERT) ? plen_sat : depth_sat;
          lvl    <= '0;
          cur    <= '0;
          hit    <= 1'b0;
          best   <= '0;
        end
      end
      ST_WALK: begin
        hit  <= hit_next;
        best <= best_next;
        if (go_on) begin
          cur    <= child;
          lvl    <= lvl + LEVEL_W'(1);
          addr_q <= addr_q << 1;
        end else begin
          node_q <= node_rd;
          rem    <= limit - lvl;
          if (cmd_q == CMD_INSERT) begin
            result <= '{match_port: '0, found: 1'b0, status: STATUS_DONE};
          end else begin
            result <= '{match_port: hit_next ? best_next : '0, found: hit_next,
                        status: STATUS_DONE};
          end
        end
      end
      ST_CHECK: begin
        if (next_free_node > NC_V || NW'(rem) > space) begin
          result.status <= STATUS_FULL;
        end
      end
      ST_WCUR: begin
        addr_q <= addr_q << 1;
      end
      ST_WNEW: begin
        addr_q <= addr_q << 1;
        rem    <= rem - LEVEL_W'(1);
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("node store written while idle");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free_node <= NC_V && next_free_node != '0)
    else $error("free node pointer out of range");
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_FULL) |-> (!result.found && result.match_port == '0))
    else $error("failed insert reported a match");
  a_alloc_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WNEW) |-> (next_free_node < NC_V))
    else $error("allocation beyond node store");
`endif

endmodule

`default_nettype wire

/* rtl/binary_trie_prefix_match_core.sv */
// top level of the binary trie longest prefix match engine
//
//   channel   direction  handshake                 payload
//   request   in         start, busy               request (req_t)
//   result    out        done (one-cycle strobe)   result (rsp_t)
//   config    in         cfg_valid, cfg_ready      cfg_data (lookup depth)
//
// a lookup walks one trie level per cycle from the node store, one read each:
// done and the result are registered when the walk stops
// an insert walks the existing path, checks for room and reports full if there is none,
// else writes the branch node and then one new node a cycle
// reset clears the control state only; the root carries a valid bit, so no
// clearing pass runs and requests are taken right after reset
// the receiver cannot stall: done is high for exactly one cycle per request
`default_nettype none

module binary_trie_prefix_match_core
  import btpm_pkg::*;
#(
  parameter int NODE_COUNT   = DEF_NODE_COUNT,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire req_t               request,
  output logic                    done,
  output rsp_t                    result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LEVEL_W-1:0] cfg_data
);

  localparam int IW     = $clog2(NODE_COUNT);
  localparam int NODE_W = 2 * IW + 1 + PORT_W;

  // lookup depth register: the user must write it only between requests; the block does not enforce this
  logic [LEVEL_W-1:0] lookup_depth;

  // node store port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [NODE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [NODE_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_depth <= DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lookup_depth <= cfg_data;
    end
  end

  // sequencer: walk, room check, write-back of the new branch
  btpm_ctrl #(
    .NODE_COUNT  (NODE_COUNT),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .lookup_depth(lookup_depth),
    .done        (done),
    .result      (result),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // node store: left child, right child, route mark, port
  btpm_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_COUNT)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire

/* tb/trie_route_checker.sv */
// result checker for the binary trie prefix match engine: predicts each request and compares
`default_nettype none

module trie_route_checker
  import btpm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire req_t               request,
  input  wire logic               done,
  input  wire rsp_t               result,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [LEVEL_W-1:0] cfg_data,
  output int                      mismatches,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = DEF_NODE_COUNT;
  localparam int ABITS = DEF_ADDRESS_BITS;
  localparam int IDX_W = $clog2(NODES);

  // shadow node store
  logic [IDX_W-1:0]  kid_lo   [NODES];
  logic [IDX_W-1:0]  kid_hi   [NODES];
  logic              marked   [NODES];
  logic [PORT_W-1:0] hop_port [NODES];
  logic [IDX_W:0]    free_node;
  logic [LEVEL_W-1:0] depth_q;

  rsp_t due_route [$];
  rsp_t want;
  int   err_cnt;

  function automatic int branch(int node, logic b);
    return b ? int'(kid_hi[node]) : int'(kid_lo[node]);
  endfunction

  // insert or longest-prefix lookup against the shadow store
  function automatic rsp_t walk_trie(req_t r);
    rsp_t o;
    int   plen;
    int   reached;
    int   lvl;
    int   cur;
    int   nx;
    int   depth;
    o   = '0;
    cur = 0;
    if (r.command == CMD_INSERT) begin
      plen    = (int'(r.prefix_length) > ABITS) ? ABITS : int'(r.prefix_length);
      reached = 0;
      while (reached < plen) begin
        nx = branch(cur, r.ip_address[ABITS-1-reached]);
        if (nx == 0) break;
        cur = nx;
        reached++;
      end
      if (int'(free_node) > NODES || plen - reached > NODES - int'(free_node)) begin
        o.status = STATUS_FULL;
      end else begin
        for (lvl = reached; lvl < plen; lvl++) begin
          nx            = int'(free_node);
          free_node     = free_node + 1'b1;
          kid_lo[nx]    = '0;
          kid_hi[nx]    = '0;
          marked[nx]    = 1'b0;
          hop_port[nx]  = '0;
          if (r.ip_address[ABITS-1-lvl]) kid_hi[cur] = IDX_W'(nx);
          else kid_lo[cur] = IDX_W'(nx);
          cur = nx;
        end
        marked[cur]   = 1'b1;
        hop_port[cur] = r.route_port;
      end
    end else begin
      depth = (int'(depth_q) > ABITS) ? ABITS : int'(depth_q);
      if (marked[0]) begin
        o.found      = 1'b1;
        o.match_port = hop_port[0];
      end
      for (lvl = 0; lvl < depth; lvl++) begin
        nx = branch(cur, r.ip_address[ABITS-1-lvl]);
        if (nx == 0) break;
        cur = nx;
        if (marked[cur]) begin
          o.found      = 1'b1;
          o.match_port = hop_port[cur];
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NODES; n++) begin
        kid_lo[n]   = '0;
        kid_hi[n]   = '0;
        marked[n]   = 1'b0;
        hop_port[n] = '0;
      end
      free_node = (IDX_W+1)'(1);
      depth_q   = DEPTH_RESET;
      due_route.delete();
      err_cnt   = 0;
    end else begin
      if (cfg_valid && cfg_ready) depth_q = cfg_data;
      if (done) begin
        if (due_route.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no request waiting: expected none, got %p", $time, result);
        end else begin
          want = due_route.pop_front();
          if (result.match_port !== want.match_port) begin
            err_cnt++;
            $display("%0t: match_port expected %h, got %h", $time, want.match_port,
                     result.match_port);
          end
          if (result.found !== want.found) begin
            err_cnt++;
            $display("%0t: found expected %b, got %b", $time, want.found, result.found);
          end
          if (result.status !== want.status) begin
            err_cnt++;
            $display("%0t: status expected %b, got %b", $time, want.status, result.status);
          end
        end
      end
      if (start && !busy) due_route = {due_route, walk_trie(request)};
    end
    mismatches <= err_cnt;
    pending    <= due_route.size();
  end

endmodule

`default_nettype wire

/* tb/binary_trie_prefix_match_core_tb.sv */
// testbench top of the binary trie prefix match engine: stimulus, watchdog and verdict
`default_nettype none

module binary_trie_prefix_match_core_tb import btpm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no request, result or config write before giving up
  localparam int STALL_LIMIT = 2000;
  // number of network addresses that most random traffic clusters around
  localparam int POOL_N      = 12;

  logic               clk;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  req_t               request   = '0;
  logic               cfg_valid = 1'b0;
  logic [LEVEL_W-1:0] cfg_data  = '0;
  logic               busy;
  logic               done;
  logic               cfg_ready;
  rsp_t               result;

  int mismatch_cnt;
  int open_cnt;
  int stall_cnt = 0;

  logic [ADDR_W-1:0] net_pool [POOL_N];

  binary_trie_prefix_match_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  trie_route_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatch_cnt),
    .pending    (open_cnt)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: any accepted request, result strobe or config write restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("binary_trie_prefix_match_core_tb: errors");
      $finish;
    end
  end

  function automatic req_t route_req(logic cmd, logic [ADDR_W-1:0] addr, int plen, int port);
    req_t r;
    r.command       = cmd;
    r.ip_address    = addr;
    r.prefix_length = LEVEL_W'(plen);
    r.route_port    = PORT_W'(port);
    return r;
  endfunction

  // random request: mostly addresses near a pool entry so routes nest and lookups go deep,
  // with a few fully random addresses as noise; flood gives fresh /32 inserts to fill the store
  function automatic req_t draw_request(bit flood);
    req_t              r;
    int                k;
    int                pick;
    logic [ADDR_W-1:0] mask;
    r.route_port = PORT_W'($urandom);
    if (flood) begin
      r.command       = CMD_INSERT;
      r.ip_address    = $urandom;
      r.prefix_length = LEVEL_W'(32);
      return r;
    end
    r.command = $urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      r.ip_address = $urandom;
    end else begin
      // mostly vary the low bits only, sometimes reach higher up the trie
      k    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
      mask = (k == 32) ? '1 : ((32'd1 << k) - 32'd1);
      r.ip_address = net_pool[$urandom_range(0, POOL_N-1)] ^ ($urandom & mask);
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) r.prefix_length = LEVEL_W'($urandom_range(0, 32));
    else if (pick < 9) r.prefix_length = LEVEL_W'($urandom_range(16, 32));
    else r.prefix_length = LEVEL_W'($urandom_range(33, 63));
    return r;
  endfunction

  // present one request, hold it until taken; start drops only if a gap or a pause follows
  task automatic issue(req_t r, int gap, bit last);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    if (last || gap > 0) start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // wait until every request has its result and the engine is idle
  task automatic drain();
    @(posedge clk);
    while (open_cnt != 0 || busy) @(posedge clk);
  endtask

  // lookup depth is only changed while the engine is idle
  task automatic set_depth(logic [LEVEL_W-1:0] depth);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= depth;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // calm phases send back to back, others idle in random bursts
  task automatic run_phase(int count, bit flood, bit calm);
    int gap;
    for (int k = 0; k < count; k++) begin
      gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 18);
      issue(draw_request(flood), gap, k == count - 1);
    end
  endtask

  initial begin
    logic [LEVEL_W-1:0] depth_plan [8];
    // zero and maximum depth, saturation above the address width, and a random pick
    depth_plan    = '{6'd0, 6'd63, 6'd1, 6'd17, 6'd31, 6'd33, 6'd32, 6'd0};
    depth_plan[7] = LEVEL_W'($urandom_range(0, 63));
    for (int p = 0; p < POOL_N; p++) net_pool[p] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed requests at the reset depth
    issue(route_req(CMD_LOOKUP, 32'h0000_0000, 0, 0), 0, 0);        // empty trie
    issue(route_req(CMD_INSERT, 32'h1234_5678, 0, 16'hFFFF), 0, 0); // default route
    issue(route_req(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0), 0, 0);
    issue(route_req(CMD_INSERT, 32'hFFFF_FFFF, 32, 16'h1234), 0, 0);
    issue(route_req(CMD_INSERT, 32'hFFFF_FFFF, 63, 16'hABCD), 0, 0); // long prefix, overwrite
    issue(route_req(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0), 0, 0);
    issue(route_req(CMD_INSERT, 32'h0000_0000, 32, 16'h0000), 3, 0); // match with port zero
    issue(route_req(CMD_LOOKUP, 32'h0000_0000, 0, 0), 0, 0);
    issue(route_req(CMD_INSERT, 32'hC0A8_0000, 16, 16'h0101), 0, 0);
    issue(route_req(CMD_INSERT, 32'hC0A8_0100, 24, 16'h0202), 0, 0);
    issue(route_req(CMD_LOOKUP, 32'hC0A8_0105, 0, 0), 0, 0);        // longest of nested routes
    issue(route_req(CMD_LOOKUP, 32'hC0A8_0205, 0, 0), 7, 0);
    issue(route_req(CMD_LOOKUP, 32'hC0A9_0000, 0, 0), 0, 0);        // falls back to default
    issue(route_req(CMD_INSERT, 32'h8000_0000, 1, 16'h8000), 0, 0);
    issue(route_req(CMD_LOOKUP, 32'h7FFF_FFFF, 0, 0), 0, 0);
    issue(route_req(CMD_LOOKUP, 32'h8000_0001, 0, 0), 0, 0);
    issue(route_req(CMD_INSERT, 32'h0000_0000, 0, 16'h5555), 0, 0); // default overwritten
    issue(route_req(CMD_INSERT, 32'hAAAA_AAAA, 33, 16'h0F0F), 0, 0);
    issue(route_req(CMD_INSERT, 32'h5555_5555, 31, 16'hF0F0), 1, 0);
    issue(route_req(CMD_LOOKUP, 32'h5555_5554, 0, 0), 0, 0);
    issue(route_req(CMD_LOOKUP, 32'hAAAA_AAAA, 0, 0), 0, 0);
    issue(route_req(CMD_LOOKUP, 32'h5555_5555, 63, 16'hFFFF), 0, 1); // ignored fields high

    // random traffic over a range of lookup depths
    for (int ph = 0; ph < 8; ph++) begin
      set_depth(depth_plan[ph]);
      run_phase(170, 1'b0, $urandom_range(0, 3) == 0);
    end

    // fill the node store until inserts come back full
    set_depth(DEPTH_RESET);
    run_phase(250, 1'b1, 1'b0);

    // traffic against a full store, no idling at the end of the run
    set_depth(LEVEL_W'($urandom_range(20, 63)));
    run_phase(150, 1'b0, 1'b1);

    drain();
    // room for a stray late result to show up
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("binary_trie_prefix_match_core_tb: clean");
    end else begin
      $display("binary_trie_prefix_match_core_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
